/* rtl/rbis_pkg.sv */
`timescale 1ns / 1ps

package rbis_pkg;

	// value format: signed, VALUE_WIDTH bits
	localparam int VALUE_WIDTH = 32;

	// register file
	localparam int ADDR_WIDTH = 3;
	localparam logic REG_TIME_STEP = 1'b0;
	localparam logic REG_MAX_SPEED = 1'b1;
	localparam logic [15:0] TS_RESET = 16'd1092;
	localparam logic [30:0] MS_RESET = 31'd65536000;

	// item selector codes
	localparam logic [1:0] OP_LINEAR = 2'd0;
	localparam logic [1:0] OP_ANGULAR = 2'd1;
	localparam logic [1:0] OP_STATIC = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic signed [VALUE_WIDTH-1:0] pos_x;
		logic signed [VALUE_WIDTH-1:0] pos_y;
		logic signed [VALUE_WIDTH-1:0] pos_z;
		logic signed [VALUE_WIDTH-1:0] vel_x;
		logic signed [VALUE_WIDTH-1:0] vel_y;
		logic signed [VALUE_WIDTH-1:0] vel_z;
		logic signed [VALUE_WIDTH-1:0] force_x;
		logic signed [VALUE_WIDTH-1:0] force_y;
		logic signed [VALUE_WIDTH-1:0] force_z;
		logic [VALUE_WIDTH-1:0] inertia;
		logic [15:0] damping;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] new_pos_x;
		logic signed [VALUE_WIDTH-1:0] new_pos_y;
		logic signed [VALUE_WIDTH-1:0] new_pos_z;
		logic signed [VALUE_WIDTH-1:0] new_vel_x;
		logic signed [VALUE_WIDTH-1:0] new_vel_y;
		logic signed [VALUE_WIDTH-1:0] new_vel_z;
		logic was_clamped;
	} out_word_t;

endpackage

/* rtl/rigid_body_integration_step.sv */
`timescale 1ns / 1ps

// One semi-implicit Euler step per body, streamed.
// Input channel: item / item_valid / item_stall; a word is taken on a clock
// edge with item_valid high and item_stall low. Output channel: result /
// result_valid / result_stall, same rule. time_step and max_speed sit on the
// APB port at byte addresses 0 and 4; the user must write them only while idle,
// as the block itself does not enforce it. Throughput: one word per cycle
// while result_stall does not hold the output; the delay is set by the force
// divider, the square-root pipeline and the clamp divider, each bit-per-stage.
// The pipeline advances as one unit: when the output word is held by
// result_stall, every stage holds and item_stall is raised, so nothing is
// lost or repeated. Reset clears all valid bits and loads the register
// defaults (time_step 1092, max_speed 65536000).
module rigid_body_integration_step #(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  rbis_pkg::in_word_t item,
	output logic result_valid,
	input  logic result_stall,
	output rbis_pkg::out_word_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [rbis_pkg::ADDR_WIDTH-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int W = rbis_pkg::VALUE_WIDTH;
	localparam int QA = W + FRACTION_BITS;
	localparam int QB = 31;
	localparam int SATW = W + 32;
	localparam int SUMW = 2 * W;
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	typedef logic [2:0][W-1:0] vec_t;

	typedef struct packed {
		logic [1:0] op;
		vec_t p;
		vec_t v;
		vec_t fmag;
		logic [2:0] fneg;
		logic [2:0] fzero;
		logic [W-1:0] m;
		logic [31:0] b;
	} front_t;

	typedef struct packed {
		logic [1:0] op;
		vec_t p;
		vec_t v;
		logic [2:0] fneg;
		logic [2:0] fzero;
		logic mzero;
		logic [31:0] f;
	} mid_t;

	typedef struct packed {
		logic [1:0] op;
		vec_t p;
		vec_t v;
		vec_t vd;
		logic over;
	} back_t;

	typedef struct packed {
		logic [1:0] op;
		vec_t p;
		vec_t v;
		vec_t vc;
		logic clamped;
	} tail_t;

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	// magnitude and sign back to a saturated signed value
	function automatic logic [W-1:0] sat(input logic [SATW-1:0] m, input logic neg);
		logic [SATW-1:0] lim;
		lim = neg ? (SATW'(VMAX) + 1'b1) : SATW'(VMAX);
		if (m > lim) return neg ? VMIN : VMAX;
		return neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
	endfunction

	function automatic logic [W-1:0] addsat(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
		return s[W-1:0];
	endfunction

	// configuration registers
	logic [15:0] ts_q;
	logic [30:0] ms_q;
	logic [61:0] ms_sq_q;
	logic wr;

	assign wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= rbis_pkg::TS_RESET;
			ms_q <= rbis_pkg::MS_RESET;
		end else if (wr) begin
			unique case (paddr[2])
				rbis_pkg::REG_TIME_STEP: ts_q <= pwdata[15:0];
				rbis_pkg::REG_MAX_SPEED: ms_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ms_sq_q <= 62'(ms_q) * 62'(ms_q);
	end

	always_comb begin
		unique case (paddr[2])
			rbis_pkg::REG_TIME_STEP: prdata = 32'(ts_q);
			rbis_pkg::REG_MAX_SPEED: prdata = 32'(ms_q);
			default: prdata = '0;
		endcase
	end

	// whole pipeline holds while the output word waits
	logic en;
	logic v_s13;

	assign en = !(v_s13 && result_stall);
	assign item_stall = !en;

	// stage 1: register the word, split forces into sign and magnitude
	logic v_s1;
	front_t fr_s1;
	vec_t in_pos, in_vel, in_frc;

	assign in_pos = {item.pos_z, item.pos_y, item.pos_x};
	assign in_vel = {item.vel_z, item.vel_y, item.vel_x};
	assign in_frc = {item.force_z, item.force_y, item.force_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s1.op <= item.op;
			fr_s1.p <= in_pos;
			fr_s1.v <= in_vel;
			for (int i = 0; i < 3; i++) begin
				fr_s1.fmag[i] <= mag(in_frc[i]);
				fr_s1.fneg[i] <= in_frc[i][W-1];
				fr_s1.fzero[i] <= (in_frc[i] == '0);
			end
			fr_s1.m <= item.inertia;
			// damping rides in the drag field until the base is formed
			fr_s1.b <= 32'(item.damping);
		end
	end

	// stage 2: drag base 1 - damping*dt/256 in unsigned Q1.31
	logic drag_v_s [0:8];
	front_t drag_s [0:8];
	logic [31:0] x_s1;
	front_t base_s1;

	assign x_s1 = 32'(fr_s1.b[15:0]) * 32'(ts_q);

	always_comb begin
		base_s1 = fr_s1;
		base_s1.b = 32'h8000_0000 - {1'b0, x_s1[31:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drag_v_s[0] <= 1'b0;
		end else if (en) begin
			drag_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drag_s[0] <= base_s1;
		end
	end

	// eight squaring stages give the drag factor
	for (genvar k = 1; k <= 8; k++) begin : g_drag
		logic [63:0] sq;
		front_t nx;

		assign sq = 64'(drag_s[k-1].b) * 64'(drag_s[k-1].b);

		always_comb begin
			nx = drag_s[k-1];
			nx.b = sq[62:31];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				drag_v_s[k] <= 1'b0;
			end else if (en) begin
				drag_v_s[k] <= drag_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				drag_s[k] <= nx;
			end
		end
	end

	// acceleration magnitude = (|force| << FRACTION_BITS) / inertia
	mid_t mid_in, da_mid;
	logic [$bits(mid_t)-1:0] da_side;
	logic [2:0][W-1:0] da_rem;
	logic [2:0][QA-1:0] da_num;
	logic [2:0][QA-1:0] da_q;
	logic da_v;

	assign mid_in.op = drag_s[8].op;
	assign mid_in.p = drag_s[8].p;
	assign mid_in.v = drag_s[8].v;
	assign mid_in.fneg = drag_s[8].fneg;
	assign mid_in.fzero = drag_s[8].fzero;
	assign mid_in.mzero = (drag_s[8].m == '0);
	assign mid_in.f = drag_s[8].b;
	assign da_rem = '0;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			da_num[i] = {drag_s[8].fmag[i], {FRACTION_BITS{1'b0}}};
		end
	end

	rbis_div #(
		.LANES(3),
		.DW(W),
		.QW(QA),
		.SW($bits(mid_t))
	) u_div_acc (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(drag_v_s[8]),
		.rem_in(da_rem),
		.num_in(da_num),
		.den_in(drag_s[8].m),
		.side_in(mid_in),
		.out_valid(da_v),
		.quo(da_q),
		.side_out(da_side)
	);

	assign da_mid = da_side;

	// stage 3: saturate acceleration, zero inertia gives the extreme unless the force is zero
	logic v_s3;
	mid_t mid_s3;
	vec_t a_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= da_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s3 <= da_mid;
			for (int i = 0; i < 3; i++) begin
				if (da_mid.mzero) begin
					a_s3[i] <= da_mid.fzero[i] ? '0 : (da_mid.fneg[i] ? VMIN : VMAX);
				end else begin
					a_s3[i] <= sat(SATW'(da_q[i]), da_mid.fneg[i]);
				end
			end
		end
	end

	// stage 4: acceleration times dt
	logic v_s4;
	mid_t mid_s4;
	logic [2:0][W+15:0] prod_s4;
	logic [2:0] aneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s4 <= mid_s3;
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= (W+16)'(mag(a_s3[i])) * (W+16)'(ts_q);
				aneg_s4[i] <= a_s3[i][W-1];
			end
		end
	end

	// stage 5: velocity plus the step
	logic v_s5;
	mid_t mid_s5;
	vec_t vn_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s5 <= mid_s4;
			for (int i = 0; i < 3; i++) begin
				vn_s5[i] <= addsat(mid_s4.v[i],
					sat(SATW'(prod_s4[i][W+15:16]), aneg_s4[i]));
			end
		end
	end

	// stage 6: velocity times drag factor
	logic v_s6;
	mid_t mid_s6;
	logic [2:0][W+31:0] prod_s6;
	logic [2:0] vneg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s6 <= mid_s5;
			for (int i = 0; i < 3; i++) begin
				prod_s6[i] <= (W+32)'(mag(vn_s5[i])) * (W+32)'(mid_s5.f);
				vneg_s6[i] <= vn_s5[i][W-1];
			end
		end
	end

	// stage 7: damped velocity
	logic v_s7;
	mid_t mid_s7;
	vec_t vd_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s7 <= mid_s6;
			for (int i = 0; i < 3; i++) begin
				vd_s7[i] <= sat(SATW'(prod_s6[i][W+31:31]), vneg_s6[i]);
			end
		end
	end

	// stage 8: squared components
	logic v_s8;
	mid_t mid_s8;
	vec_t vd_s8;
	logic [2:0][SUMW-1:0] sq_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s8 <= mid_s7;
			vd_s8 <= vd_s7;
			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= SUMW'(mag(vd_s7[i])) * SUMW'(mag(vd_s7[i]));
			end
		end
	end

	// stage 9: squared speed and limit test
	logic v_s9;
	back_t back_s9;
	logic [SUMW-1:0] sum_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s9 <= sq_s8[0] + sq_s8[1] + sq_s8[2];
			back_s9.op <= mid_s8.op;
			back_s9.p <= mid_s8.p;
			back_s9.v <= mid_s8.v;
			back_s9.vd <= vd_s8;
			back_s9.over <= ((sq_s8[0] + sq_s8[1] + sq_s8[2]) > SUMW'(ms_sq_q));
		end
	end

	// speed = isqrt(sum)
	logic sr_v;
	logic [W-1:0] sr_root;
	logic [$bits(back_t)-1:0] sr_side;
	back_t sr_back;

	rbis_sqrt #(
		.RW(W),
		.SW($bits(back_t))
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s9),
		.rad_in(sum_s9),
		.side_in(back_s9),
		.out_valid(sr_v),
		.root(sr_root),
		.side_out(sr_side)
	);

	assign sr_back = sr_side;

	// stage 10: |v| * max_speed
	logic v_s10;
	back_t back_s10;
	logic [W-1:0] speed_s10;
	logic [2:0][W+30:0] num_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= sr_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			back_s10 <= sr_back;
			speed_s10 <= sr_root;
			for (int i = 0; i < 3; i++) begin
				num_s10[i] <= (W+31)'(mag(sr_back.vd[i])) * (W+31)'(ms_q);
			end
		end
	end

	// rescale: quotient never exceeds max_speed, so the high part seeds the remainder
	logic [2:0][W-1:0] db_rem;
	logic [2:0][QB-1:0] db_num;
	logic [2:0][QB-1:0] db_q;
	logic db_v;
	logic [$bits(back_t)-1:0] db_side;
	back_t db_back;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			db_rem[i] = num_s10[i][W+30:31];
			db_num[i] = num_s10[i][30:0];
		end
	end

	rbis_div #(
		.LANES(3),
		.DW(W),
		.QW(QB),
		.SW($bits(back_t))
	) u_div_clamp (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s10),
		.rem_in(db_rem),
		.num_in(db_num),
		.den_in(speed_s10),
		.side_in(back_s10),
		.out_valid(db_v),
		.quo(db_q),
		.side_out(db_side)
	);

	assign db_back = db_side;

	// stage 11: pick clamped or damped velocity
	logic v_s11;
	tail_t tail_s11;
	logic clamp;

	assign clamp = (db_back.op == rbis_pkg::OP_LINEAR) && db_back.over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= db_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s11.op <= db_back.op;
			tail_s11.p <= db_back.p;
			tail_s11.v <= db_back.v;
			tail_s11.clamped <= clamp;
			for (int i = 0; i < 3; i++) begin
				tail_s11.vc[i] <= clamp ? sat(SATW'(db_q[i]), db_back.vd[i][W-1])
					: db_back.vd[i];
			end
		end
	end

	// stage 12: velocity times dt
	logic v_s12;
	tail_t tail_s12;
	logic [2:0][W+15:0] prod_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s12 <= tail_s11;
			for (int i = 0; i < 3; i++) begin
				prod_s12[i] <= (W+16)'(mag(tail_s11.vc[i])) * (W+16)'(ts_q);
			end
		end
	end

	// stage 13: new position, static and spare-code words pass through
	rbis_pkg::out_word_t res_s13;
	vec_t pn;
	logic moving;

	assign moving = (tail_s12.op == rbis_pkg::OP_LINEAR)
		|| (tail_s12.op == rbis_pkg::OP_ANGULAR);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pn[i] = addsat(tail_s12.p[i],
				sat(SATW'(prod_s12[i][W+15:16]), tail_s12.vc[i][W-1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (moving) begin
				res_s13.new_pos_x <= pn[0];
				res_s13.new_pos_y <= pn[1];
				res_s13.new_pos_z <= pn[2];
				res_s13.new_vel_x <= tail_s12.vc[0];
				res_s13.new_vel_y <= tail_s12.vc[1];
				res_s13.new_vel_z <= tail_s12.vc[2];
				res_s13.was_clamped <= tail_s12.clamped;
			end else begin
				res_s13.new_pos_x <= tail_s12.p[0];
				res_s13.new_pos_y <= tail_s12.p[1];
				res_s13.new_pos_z <= tail_s12.p[2];
				res_s13.new_vel_x <= tail_s12.v[0];
				res_s13.new_vel_y <= tail_s12.v[1];
				res_s13.new_vel_z <= tail_s12.v[2];
				res_s13.was_clamped <= 1'b0;
			end
		end
	end

	assign result_valid = v_s13;
	assign result = res_s13;

endmodule

/* rtl/rbis_div.sv */
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage, shared divisor
module rbis_div #(
	parameter int LANES = 3,
	parameter int DW = 32,
	parameter int QW = 48,
	parameter int SW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [LANES-1:0][DW-1:0] rem_in,
	input  logic [LANES-1:0][QW-1:0] num_in,
	input  logic [DW-1:0] den_in,
	input  logic [SW-1:0] side_in,
	output logic out_valid,
	output logic [LANES-1:0][QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic vld_s [0:QW];
	logic [LANES-1:0][DW-1:0] rem_s [0:QW];
	logic [LANES-1:0][QW-1:0] num_s [0:QW];
	logic [LANES-1:0][QW-1:0] quo_s [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic [SW-1:0] side_s [0:QW];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = rem_in;
	assign num_s[0] = num_in;
	assign quo_s[0] = '0;
	assign den_s[0] = den_in;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [LANES-1:0][DW-1:0] rem_nx;
		logic [LANES-1:0][QW-1:0] quo_nx;

		// trial subtract of the next numerator bit
		always_comb begin
			logic [DW:0] t;
			logic ge;
			for (int l = 0; l < LANES; l++) begin
				t = {rem_s[k][l], num_s[k][l][QW-1]};
				ge = (t >= {1'b0, den_s[k]});
				rem_nx[l] = ge ? DW'(t - {1'b0, den_s[k]}) : t[DW-1:0];
				quo_nx[l] = {quo_s[k][l][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				quo_s[k+1] <= quo_nx;
				for (int l = 0; l < LANES; l++) begin
					num_s[k+1][l] <= {num_s[k][l][QW-2:0], 1'b0};
				end
				den_s[k+1] <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

/* rtl/rbis_sqrt.sv */
`timescale 1ns / 1ps

// pipelined integer square root, one root bit per stage
module rbis_sqrt #(
	parameter int RW = 32,
	parameter int SW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2*RW-1:0] rad_in,
	input  logic [SW-1:0] side_in,
	output logic out_valid,
	output logic [RW-1:0] root,
	output logic [SW-1:0] side_out
);

	logic vld_s [0:RW];
	logic [RW+1:0] rem_s [0:RW];
	logic [RW-1:0] root_s [0:RW];
	logic [2*RW-1:0] rad_s [0:RW];
	logic [SW-1:0] side_s [0:RW];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad_in;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+3:0] t;
		logic [RW+3:0] trial;
		logic ge;

		// bring down two radicand bits and try root*4+1
		assign t = {rem_s[k], rad_s[k][2*RW-1:2*RW-2]};
		assign trial = (RW+4)'({root_s[k], 2'b01});
		assign ge = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? (RW+2)'(t - trial) : t[RW+1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				rad_s[k+1] <= {rad_s[k][2*RW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign root = root_s[RW];
	assign side_out = side_s[RW];

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 200;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	rbis_pkg::in_word_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	rbis_pkg::out_word_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [rbis_pkg::ADDR_WIDTH-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rigid_body_integration_step u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the step and speed registers
	logic [15:0] step_cfg = rbis_pkg::TS_RESET;
	logic [30:0] speed_cfg = rbis_pkg::MS_RESET;

	rbis_pkg::in_word_t bodies_q[$];
	rbis_pkg::out_word_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	// arithmetic helpers for the integrator
	function automatic longint unsigned mag(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint clip(logic [127:0] m, bit neg);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (m > lim)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	function automatic longint scale(longint a, longint unsigned b, int s);
		logic [127:0] p;
		p = {64'b0, mag(a)} * {64'b0, b};
		return clip(p >> s, a < 0);
	endfunction

	function automatic longint add_clip(longint a, longint b);
		longint s;
		s = a + b;
		if (s > 64'sd2147483647) return 64'sd2147483647;
		if (s < -64'sd2147483648) return -64'sd2147483648;
		return s;
	endfunction

	function automatic longint unsigned root(logic [127:0] n);
		longint unsigned r, t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'b0, t} * {64'b0, t} <= n) r = t;
		end
		return r;
	endfunction

	// drag factor: (1 - damping*step/256)^256 in unsigned Q1.31
	function automatic longint unsigned drag(logic [15:0] damping);
		longint unsigned x, b;
		x = longint'(damping) * longint'(step_cfg);
		b = (64'd1 << 31) - (x >> 1);
		for (int i = 0; i < 8; i++) b = (b * b) >> 31;
		return b;
	endfunction

	// one semi-implicit euler step
	function automatic rbis_pkg::out_word_t integrate_body(rbis_pkg::in_word_t w);
		rbis_pkg::out_word_t r;
		longint p[3], v[3], f[3], a;
		longint unsigned kd, speed;
		logic [127:0] sum, q;
		bit clamped;
		p = '{longint'(w.pos_x), longint'(w.pos_y), longint'(w.pos_z)};
		v = '{longint'(w.vel_x), longint'(w.vel_y), longint'(w.vel_z)};
		f = '{longint'(w.force_x), longint'(w.force_y), longint'(w.force_z)};
		clamped = 1'b0;
		if (w.op == rbis_pkg::OP_LINEAR || w.op == rbis_pkg::OP_ANGULAR) begin
			kd = drag(w.damping);
			for (int i = 0; i < 3; i++) begin
				if (w.inertia == 0)
					a = f[i] == 0 ? 0 : (f[i] < 0 ? -64'sd2147483648 : 64'sd2147483647);
				else begin
					q = ({64'b0, mag(f[i])} << 16) / {96'b0, w.inertia};
					a = clip(q, f[i] < 0);
				end
				v[i] = add_clip(v[i], scale(a, step_cfg, 16));
				v[i] = scale(v[i], kd, 31);
			end
			if (w.op == rbis_pkg::OP_LINEAR) begin
				sum = '0;
				for (int i = 0; i < 3; i++)
					sum += {64'b0, mag(v[i])} * {64'b0, mag(v[i])};
				if (sum > {97'b0, speed_cfg} * {97'b0, speed_cfg}) begin
					speed = root(sum);
					clamped = 1'b1;
					for (int i = 0; i < 3; i++) begin
						q = ({64'b0, mag(v[i])} * {97'b0, speed_cfg}) / {64'b0, speed};
						v[i] = clip(q, v[i] < 0);
					end
				end
			end
			for (int i = 0; i < 3; i++) p[i] = add_clip(p[i], scale(v[i], step_cfg, 16));
		end
		r.new_pos_x = p[0][31:0];
		r.new_pos_y = p[1][31:0];
		r.new_pos_z = p[2][31:0];
		r.new_vel_x = v[0][31:0];
		r.new_vel_y = v[1][31:0];
		r.new_vel_z = v[2][31:0];
		r.was_clamped = clamped;
		return r;
	endfunction

	// idle lengths: mostly short, a few long
	function automatic int gap_len();
		int k;
		if (calm) return 0;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// word driver
	int send_gap = 0;
	always @(posedge clk) begin
		bit accepted;
		bit nv;
		if (arst_n) begin
			accepted = item_valid && !item_stall;
			if (accepted) begin
				expected_q.push_back(integrate_body(item));
				idle_cycles = 0;
			end
			if (!item_valid || accepted) begin
				nv = 1'b0;
				if (send_gap > 0)
					send_gap--;
				else if (bodies_q.size() > 0) begin
					item <= bodies_q.pop_front();
					nv = 1'b1;
					send_gap = gap_len();
				end
				item_valid <= nv;
			end
		end
	end

	// result stall driver
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			stall_left = gap_len();
			result_stall <= stall_left > 0;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		rbis_pkg::out_word_t e;
		if (arst_n && result_valid && !result_stall) begin
			idle_cycles = 0;
			if (expected_q.size() == 0) begin
				$error("unexpected result word %h", result);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result.new_pos_x !== e.new_pos_x) begin
					$error("new_pos_x: expected %h, got %h", e.new_pos_x, result.new_pos_x);
					errors++;
				end
				if (result.new_pos_y !== e.new_pos_y) begin
					$error("new_pos_y: expected %h, got %h", e.new_pos_y, result.new_pos_y);
					errors++;
				end
				if (result.new_pos_z !== e.new_pos_z) begin
					$error("new_pos_z: expected %h, got %h", e.new_pos_z, result.new_pos_z);
					errors++;
				end
				if (result.new_vel_x !== e.new_vel_x) begin
					$error("new_vel_x: expected %h, got %h", e.new_vel_x, result.new_vel_x);
					errors++;
				end
				if (result.new_vel_y !== e.new_vel_y) begin
					$error("new_vel_y: expected %h, got %h", e.new_vel_y, result.new_vel_y);
					errors++;
				end
				if (result.new_vel_z !== e.new_vel_z) begin
					$error("new_vel_z: expected %h, got %h", e.new_vel_z, result.new_vel_z);
					errors++;
				end
				if (result.was_clamped !== e.was_clamped) begin
					$error("was_clamped: expected %b, got %b", e.was_clamped,
						result.was_clamped);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("rigid_body_integration_step test failed");
			$finish;
		end
	end

	task automatic reg_write(logic idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == rbis_pkg::REG_TIME_STEP) step_cfg = val[15:0];
		else speed_cfg = val[30:0];
		idle_cycles = 0;
	endtask

	task automatic drain();
		while (bodies_q.size() > 0 || item_valid || expected_q.size() > 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h00ff_ffff)
				: -$urandom_range(0, 32'h00ff_ffff);
			3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0003_ffff)
				: -$urandom_range(0, 32'h0003_ffff);
			default: return $urandom;
		endcase
	endfunction

	function automatic rbis_pkg::in_word_t rand_body();
		rbis_pkg::in_word_t w;
		int k;
		k = $urandom_range(0, 9);
		w.op = k < 5 ? rbis_pkg::OP_LINEAR : (k < 8 ? rbis_pkg::OP_ANGULAR
			: (k < 9 ? rbis_pkg::OP_STATIC : OP_SPARE));
		w.pos_x = rand_value();
		w.pos_y = rand_value();
		w.pos_z = rand_value();
		w.vel_x = rand_value();
		w.vel_y = rand_value();
		w.vel_z = rand_value();
		w.force_x = rand_value();
		w.force_y = rand_value();
		w.force_z = rand_value();
		case ($urandom_range(0, 3))
			0: w.inertia = $urandom_range(1, 32'h0004_0000);
			1: w.inertia = $urandom_range(1, 16);
			default: w.inertia = $urandom | 32'd1;
		endcase
		w.damping = $urandom_range(0, 2) == 0 ? 16'($urandom_range(0, 255)) : 16'($urandom);
		return w;
	endfunction

	function automatic rbis_pkg::in_word_t body(logic [1:0] op, logic [31:0] p,
			logic [31:0] v, logic [31:0] f, logic [31:0] m, logic [15:0] d);
		rbis_pkg::in_word_t w;
		w.op = op;
		w.pos_x = p;
		w.pos_y = -p;
		w.pos_z = p;
		w.vel_x = v;
		w.vel_y = v;
		w.vel_z = -v;
		w.force_x = f;
		w.force_y = 32'sd0;
		w.force_z = -f;
		w.inertia = m;
		w.damping = d;
		return w;
	endfunction

	// stimulus
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each op, zero inertia, no drag, clamp
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'h0001_0000, 32'h0002_0000,
			32'h0001_0000, 32'h0001_0000, 16'd0));
		bodies_q.push_back(body(rbis_pkg::OP_ANGULAR, 32'h0001_0000, 32'h0002_0000,
			32'h0001_0000, 32'h0001_0000, 16'd128));
		bodies_q.push_back(body(rbis_pkg::OP_STATIC, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'd1, 16'hffff));
		bodies_q.push_back(body(OP_SPARE, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'd0, 16'd5));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'd1, 16'd0));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'hffff_ffff, 16'hffff));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'd0, 32'd0, 32'h7fff_ffff,
			32'd0, 16'd0));
		bodies_q.push_back(body(rbis_pkg::OP_ANGULAR, 32'd0, 32'd0, 32'h8000_0000,
			32'd0, 16'd0));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'h0010_0000, 32'h0400_0000, 32'd0,
			32'h0001_0000, 16'd1));
		bodies_q.push_back(body(rbis_pkg::OP_ANGULAR, 32'h0010_0000, 32'h0400_0000, 32'd0,
			32'h0001_0000, 16'd1));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'hffff_ffff, 32'h03e8_0000, 32'd0,
			32'hffff_ffff, 16'd0));
		bodies_q.push_back(body(rbis_pkg::OP_LINEAR, 32'd1, 32'hffff_ffff, 32'd1, 32'd1,
			16'd256));
		drain();

		// walk through register settings, extremes first
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin
					reg_write(rbis_pkg::REG_TIME_STEP, 32'd0);
					reg_write(rbis_pkg::REG_MAX_SPEED, 32'd0);
				end
				1: begin
					reg_write(rbis_pkg::REG_TIME_STEP, 32'hffff);
					reg_write(rbis_pkg::REG_MAX_SPEED, 32'h7fff_ffff);
				end
				2: begin
					reg_write(rbis_pkg::REG_TIME_STEP, 32'hffff);
					reg_write(rbis_pkg::REG_MAX_SPEED, 32'd1);
				end
				3: begin
					reg_write(rbis_pkg::REG_TIME_STEP, 32'(rbis_pkg::TS_RESET));
					reg_write(rbis_pkg::REG_MAX_SPEED, 32'(rbis_pkg::MS_RESET));
				end
				default: begin
					reg_write(rbis_pkg::REG_TIME_STEP, $urandom_range(0, 32'hffff));
					reg_write(rbis_pkg::REG_MAX_SPEED, $urandom_range(0, 32'h7fff_ffff));
				end
			endcase
			calm = (phase == 3);
			if (phase < 3)
				for (int i = 0; i < 12; i++) bodies_q.push_back(body(
					i % 3 == 0 ? rbis_pkg::OP_ANGULAR : rbis_pkg::OP_LINEAR,
					rand_value(), rand_value(), rand_value(),
					i < 6 ? 32'h0001_0000 : $urandom | 32'd1,
					i < 4 ? 16'hffff : 16'($urandom)));
			for (int i = 0; i < 160; i++) bodies_q.push_back(rand_body());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("rigid_body_integration_step test passed");
		else
			$display("rigid_body_integration_step test failed");
		$finish;
	end

endmodule

/* rigid_body_integration_step.f */
rtl/rbis_pkg.sv
rtl/rbis_div.sv
rtl/rbis_sqrt.sv
rtl/rigid_body_integration_step.sv
test/tb_top.sv
